[rtl/assert_macros.svh]
// Assertion shorthands used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_SAME(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("same-cycle check failed");

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("next-cycle check failed");

`endif

[rtl/delfx_pkg.sv]
`default_nettype none

package delfx_pkg;

  // Byte and register widths.
  localparam int BYTE_W     = 8;
  localparam int LEN_W      = 7;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 8;

  // Shortest frame that can end: head pair plus tail pair.
  localparam int MIN_FRAME_LEN = 4;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_HEAD_FIRST  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEAD_SECOND = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TAIL_FIRST  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TAIL_SECOND = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_LEN     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_LEN     = 3'd5;

  // Reset values of the length bounds.
  localparam logic [LEN_W-1:0] MIN_LEN_RESET = 7'd4;
  localparam logic [LEN_W-1:0] MAX_LEN_RESET = 7'd65;

  typedef logic [BYTE_W-1:0] byte_t;

endpackage

`default_nettype wire

[rtl/delimited_frame_extractor.sv]
// A received word is taken in S_IDLE and checked in S_MATCH, followed by S_HEAD2
// when it completes a head pair. A word that completes a frame then goes through
// the length checks in S_LOW and S_HIGH, and an accepted frame is replayed word by
// word from the store's read port through S_RD and S_PUSH. No new received word is
// taken before S_IDLE; the sequencer shares the pair and length comparators.
// Reset: synchronous; clears control state and configuration, not the frame store.

`default_nettype none

module delimited_frame_extractor
  import delfx_pkg::*;
#(
  parameter int MAX_FRAME = 64
) (
  input  wire                   clk,
  input  wire                   rst,
  // Configuration write port.
  input  wire                   cfg_write,
  input  wire  [CFG_IDX_W-1:0]  cfg_index,
  input  wire  [CFG_DATA_W-1:0] cfg_data,
  // Received words.
  input  wire                   in_valid,
  output logic                  in_stall,
  input  wire  [BYTE_W-1:0]     rx_byte,
  // Frame words.
  output logic                  out_valid,
  input  wire                   out_stall,
  output logic [BYTE_W-1:0]     frame_byte,
  output logic                  frame_last
);

  localparam int AW    = (MAX_FRAME > 1) ? $clog2(MAX_FRAME) : 1;
  localparam int CNT_W = $clog2(MAX_FRAME + 1);
  localparam int CMP_W = (CNT_W > LEN_W) ? CNT_W : LEN_W;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MATCH = 3'd1;
  localparam logic [2:0] S_HEAD2 = 3'd2;
  localparam logic [2:0] S_LOW   = 3'd3;
  localparam logic [2:0] S_HIGH  = 3'd4;
  localparam logic [2:0] S_RD    = 3'd5;
  localparam logic [2:0] S_PUSH  = 3'd6;

  // Configuration registers.
  byte_t            head_first;
  byte_t            head_second;
  byte_t            tail_first;
  byte_t            tail_second;
  logic [LEN_W-1:0] min_len;
  logic [LEN_W-1:0] max_len;

  // Sequencer and frame state.
  logic [2:0]       state;
  byte_t            rx_hold;
  byte_t            previous_byte;
  logic             prev_usable;
  logic             inside_frame;
  logic [CNT_W-1:0] stored_count;
  logic [CNT_W-1:0] rd_idx;

  // Frame store.
  byte_t            frame_store [MAX_FRAME];
  byte_t            rd_data;
  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  byte_t            wr_data;

  // Shared units.
  byte_t            pair_a;
  byte_t            pair_b;
  logic             pair_hit;
  logic [CMP_W-1:0] cmp_x;
  logic [CMP_W-1:0] cmp_y;
  logic             cmp_lt;
  logic             out_free;
  logic             out_load;
  logic             rd_last;

  assign in_stall = (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;
  assign out_load = (state == S_PUSH) && out_free;
  assign rd_last  = ((rd_idx + CNT_W'(1)) == stored_count);

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      head_first  <= '0;
      head_second <= '0;
      tail_first  <= '0;
      tail_second <= '0;
      min_len     <= MIN_LEN_RESET;
      max_len     <= MAX_LEN_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_HEAD_FIRST:  head_first  <= cfg_data;
        REG_HEAD_SECOND: head_second <= cfg_data;
        REG_TAIL_FIRST:  tail_first  <= cfg_data;
        REG_TAIL_SECOND: tail_second <= cfg_data;
        REG_MIN_LEN:     min_len     <= cfg_data[LEN_W-1:0];
        REG_MAX_LEN:     max_len     <= cfg_data[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // Pair comparator: head pair while hunting, tail pair while collecting.
  always_comb begin
    pair_a   = inside_frame ? tail_first  : head_first;
    pair_b   = inside_frame ? tail_second : head_second;
    pair_hit = (previous_byte == pair_a) && (rx_hold == pair_b);
  end

  // Length comparator: lower bound first, then upper bound.
  always_comb begin
    case (state)
      S_LOW: begin
        cmp_x = CMP_W'(min_len);
        cmp_y = CMP_W'(stored_count);
      end
      S_HIGH: begin
        cmp_x = CMP_W'(stored_count);
        cmp_y = CMP_W'(max_len);
      end
      default: begin
        cmp_x = '0;
        cmp_y = '0;
      end
    endcase
    cmp_lt = (cmp_x < cmp_y);
  end

  // Store write selection.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = stored_count[AW-1:0];
    wr_data = rx_hold;
    case (state)
      S_MATCH: begin
        if (!inside_frame) begin
          wr_en   = prev_usable && pair_hit;
          wr_addr = '0;
          wr_data = previous_byte;
        end else begin
          wr_en   = (stored_count < CNT_W'(MAX_FRAME));
        end
      end
      S_HEAD2: begin
        wr_en   = 1'b1;
        wr_addr = AW'(1);
      end
      default: ;
    endcase
  end

  // Frame store with registered read.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      frame_store[wr_addr] <= wr_data;
    end
    rd_data <= frame_store[rd_idx[AW-1:0]];
  end

  // Output register: loaded from the store read port, cleared once taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid  <= 1'b1;
      frame_byte <= rd_data;
      frame_last <= rd_last;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      previous_byte <= '0;
      prev_usable   <= 1'b1;
      inside_frame  <= 1'b0;
      stored_count  <= '0;
      rd_idx        <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            rx_hold <= rx_byte;
            state   <= S_MATCH;
          end
        end
        S_MATCH: begin
          if (!inside_frame) begin
            // Hunting: look for the head pair.
            previous_byte <= rx_hold;
            prev_usable   <= 1'b1;
            if (prev_usable && pair_hit) begin
              state <= S_HEAD2;
            end else begin
              state <= S_IDLE;
            end
          end else if (stored_count >= CNT_W'(MAX_FRAME)) begin
            // Overflow drops the frame.
            inside_frame  <= 1'b0;
            stored_count  <= '0;
            previous_byte <= rx_hold;
            prev_usable   <= 1'b0;
            state         <= S_IDLE;
          end else begin
            stored_count  <= stored_count + CNT_W'(1);
            previous_byte <= rx_hold;
            if ((stored_count >= CNT_W'(MIN_FRAME_LEN - 1)) && pair_hit) begin
              // Tail found: the frame is closed either way.
              inside_frame <= 1'b0;
              prev_usable  <= 1'b0;
              state        <= S_LOW;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        S_HEAD2: begin
          stored_count <= CNT_W'(2);
          inside_frame <= 1'b1;
          state        <= S_IDLE;
        end
        S_LOW: begin
          if (cmp_lt) begin
            state <= S_HIGH;
          end else begin
            stored_count <= '0;
            state        <= S_IDLE;
          end
        end
        S_HIGH: begin
          rd_idx <= '0;
          if (cmp_lt) begin
            state <= S_RD;
          end else begin
            stored_count <= '0;
            state        <= S_IDLE;
          end
        end
        S_RD: begin
          state <= S_PUSH;
        end
        S_PUSH: begin
          // Move on once the read word has gone to the output register.
          if (out_free) begin
            if (rd_last) begin
              stored_count <= '0;
              state        <= S_IDLE;
            end else begin
              rd_idx <= rd_idx + CNT_W'(1);
              state  <= S_RD;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

[rtl/delfx_checker.sv]
`default_nettype none

`include "assert_macros.svh"

module delfx_checker
  import delfx_pkg::*;
(
  input wire                  clk,
  input wire                  rst,
  input wire                  in_valid,
  input wire                  in_stall,
  input wire                  out_valid,
  input wire                  out_stall,
  input wire [BYTE_W-1:0]     frame_byte,
  input wire                  frame_last
);

  // A stalled word stays offered.
  `ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid)

  // A stalled word keeps its payload.
  `ASSERT_NEXT(a_out_stable, clk, rst, out_valid && out_stall,
    $stable(frame_byte) && $stable(frame_last))

  // Each accepted word takes the sequencer out of S_IDLE, so the input stalls after it.
  `ASSERT_NEXT(a_busy_after_accept, clk, rst, in_valid && !in_stall, in_stall)

  // No new word is taken while a frame is still being replayed.
  `ASSERT_SAME(a_no_accept_mid_frame, clk, rst, out_valid && !frame_last, in_stall)

endmodule

bind delimited_frame_extractor delfx_checker u_delfx_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_stall   (in_stall),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .frame_byte (frame_byte),
  .frame_last (frame_last)
);

`default_nettype wire

[bench/tb_top.sv]
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import delfx_pkg::*;

  localparam int MAX_FRAME     = 64;
  localparam int SETTLE_CYCLES = 16;
  localparam int HOLD_CYCLES   = 400;

  typedef struct packed {
    byte_t data;
    logic  last;
  } frame_word_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  byte_t                 rx_byte = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  byte_t                 frame_byte;
  logic                  frame_last;

  delimited_frame_extractor #(
    .MAX_FRAME(MAX_FRAME)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .rx_byte   (rx_byte),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .frame_byte(frame_byte),
    .frame_last(frame_last)
  );

  // 100 MHz clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Marker and length settings as the deframer should see them.
  byte_t            head_a = '0;
  byte_t            head_b = '0;
  byte_t            tail_a = '0;
  byte_t            tail_b = '0;
  logic [LEN_W-1:0] len_floor = MIN_LEN_RESET;
  logic [LEN_W-1:0] len_ceiling = MAX_LEN_RESET;

  // Deframer state mirrored by the testbench.
  byte_t prev_byte = '0;
  logic  prev_ok = 1'b1;
  logic  collecting = 1'b0;
  byte_t frame_buf [MAX_FRAME];
  int    held = 0;

  // Received words waiting to be sent and frame words still owed by the block.
  byte_t       rx_queue [$];
  frame_word_t due_words [$];

  int words_pushed = 0;
  int words_taken = 0;
  int words_seen = 0;
  int frames_seen = 0;
  int mismatches = 0;

  int   send_gap_pct = 0;
  int   stall_pct = 0;
  logic hold_go = 1'b0;
  logic hold_off = 1'b0;

  // Advance the deframer by one received word and queue any frame it releases.
  function automatic void deframe_step(input byte_t b);
    frame_word_t w;
    if (!collecting) begin
      if (prev_ok && prev_byte == head_a && b == head_b) begin
        frame_buf[0] = prev_byte;
        frame_buf[1] = b;
        held = 2;
        collecting = 1'b1;
      end
      prev_byte = b;
      prev_ok = 1'b1;
      return;
    end
    // A word arriving on a full store kills the frame and is consumed.
    if (held >= MAX_FRAME) begin
      collecting = 1'b0;
      held = 0;
      prev_byte = b;
      prev_ok = 1'b0;
      return;
    end
    frame_buf[held] = b;
    held++;
    // The tail only counts once it lies wholly past the head pair.
    if (held >= MIN_FRAME_LEN && prev_byte == tail_a && b == tail_b) begin
      if (held > int'(len_floor) && held < int'(len_ceiling)) begin
        for (int k = 0; k < held; k++) begin
          w.data = frame_buf[k];
          w.last = (k == held - 1);
          due_words.push_back(w);
        end
      end
      collecting = 1'b0;
      held = 0;
      prev_byte = b;
      prev_ok = 1'b0;
      return;
    end
    prev_byte = b;
  endfunction

  // Sender: offer the next queued word, holding it steady while stalled.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        deframe_step(rx_byte);
        words_taken++;
      end
      if (!in_valid || !in_stall) begin
        if (rx_queue.size() > 0 && $urandom_range(99) >= send_gap_pct) begin
          in_valid <= 1'b1;
          rx_byte <= rx_queue.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  task automatic note_mismatch(input string what, input frame_word_t want);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t: %s: expected byte %02h last %0b, got byte %02h last %0b",
               $realtime, what, want.data, want.last, frame_byte, frame_last);
    end
  endtask

  // Receiver: check each frame word against the oldest one owed.
  always @(posedge clk) begin
    frame_word_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        words_seen++;
        if (frame_last) frames_seen++;
        if (due_words.size() == 0) begin
          note_mismatch("frame word with none owed", '0);
        end else begin
          want = due_words.pop_front();
          if (frame_byte !== want.data || frame_last !== want.last) begin
            note_mismatch("frame word mismatch", want);
          end
        end
      end
      out_stall <= hold_off || ($urandom_range(99) < stall_pct);
    end
  end

  // Long receiver hold-off so the block fills up and backs up its input.
  initial begin
    while (!hold_go) @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  // Register write; the block must be idle.
  task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      REG_HEAD_FIRST:  head_a = val;
      REG_HEAD_SECOND: head_b = val;
      REG_TAIL_FIRST:  tail_a = val;
      REG_TAIL_SECOND: tail_b = val;
      REG_MIN_LEN:     len_floor = val[LEN_W-1:0];
      REG_MAX_LEN:     len_ceiling = val[LEN_W-1:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic set_markers(input byte_t ha, input byte_t hb, input byte_t ta, input byte_t tb);
    set_reg(REG_HEAD_FIRST, ha);
    set_reg(REG_HEAD_SECOND, hb);
    set_reg(REG_TAIL_FIRST, ta);
    set_reg(REG_TAIL_SECOND, tb);
  endtask

  task automatic set_bounds(input int lo, input int hi);
    set_reg(REG_MIN_LEN, lo[CFG_DATA_W-1:0]);
    set_reg(REG_MAX_LEN, hi[CFG_DATA_W-1:0]);
  endtask

  // Markers lean on the byte extremes so they also turn up inside payloads.
  function automatic byte_t pick_marker();
    int r;
    r = $urandom_range(99);
    if (r < 20) return 8'h00;
    if (r < 40) return 8'hFF;
    return byte_t'($urandom_range(255));
  endfunction

  task automatic push_word(input byte_t b);
    rx_queue.push_back(b);
    words_pushed++;
  endtask

  task automatic push_list(input byte_t bytes [$]);
    foreach (bytes[i]) push_word(bytes[i]);
  endtask

  // Line noise, partly made of marker bytes to provoke near misses.
  task automatic queue_noise(input int n);
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(3);
      if (r == 0) push_word(head_a);
      else if (r == 1) push_word(tail_b);
      else push_word(byte_t'($urandom_range(255)));
    end
  endtask

  // One frame with a random body; a broken one stops short of its tail.
  task automatic queue_frame(input int body_len, input bit whole);
    push_word(head_a);
    push_word(head_b);
    for (int i = 0; i < body_len; i++) push_word(byte_t'($urandom_range(255)));
    if (whole) begin
      push_word(tail_a);
      push_word(tail_b);
    end else if ($urandom_range(1)) begin
      push_word(tail_a);
    end
  endtask

  task automatic random_traffic(input int n);
    int goal;
    int r;
    goal = words_pushed + n;
    while (words_pushed < goal) begin
      r = $urandom_range(99);
      if (r < 15) begin
        queue_noise($urandom_range(1, 4));
      end else if (r < 27) begin
        queue_frame($urandom_range(0, 6), 1'b0);
        queue_noise($urandom_range(1, 3));
      end else if (r < 31) begin
        queue_frame($urandom_range(12, 20), 1'b1);
      end else begin
        queue_frame($urandom_range(0, 8), 1'b1);
      end
    end
  endtask

  // Wait until every word is taken and every owed frame word has come back.
  task automatic drain();
    while (words_taken != words_pushed || due_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    int gap_pcts [4];
    int stall_pcts [4];
    gap_pcts = '{0, 69, 0, 32};
    stall_pcts = '{0, 0, 69, 32};

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: a zero right after reset pairs with the cleared previous
    // word, and the word that closes a frame cannot start the next one.
    push_list('{8'h00, 8'h11, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00});
    drain();

    // Tail overlapping the head, head pair inside a frame, used-up last word.
    set_markers(8'hAA, 8'h55, 8'h55, 8'hAA);
    set_bounds(3, 127);
    push_list('{8'hAA, 8'h55, 8'hAA, 8'h55, 8'hAA, 8'h55,
                8'hAA, 8'h55, 8'h00, 8'hAA, 8'h55, 8'hAA, 8'hFF});
    drain();

    // Bounds out of order: complete frames are all dropped.
    set_bounds(127, 0);
    push_list('{8'hAA, 8'h55, 8'h55, 8'hAA, 8'hAA, 8'h55, 8'h01, 8'h55, 8'hAA});
    drain();

    // Random frames under each idling pattern.
    for (int p = 0; p < 4; p++) begin
      set_markers(pick_marker(), pick_marker(), pick_marker(), pick_marker());
      if (p == 0) set_bounds(0, 127);
      else set_bounds($urandom_range(0, 8), $urandom_range(12, 80));
      send_gap_pct <= gap_pcts[p];
      stall_pct <= stall_pcts[p];
      random_traffic(6);
      drain();
    end

    // Receiver holds off while two short frames and an overflowing one between them stream in.
    set_markers(pick_marker(), pick_marker(), pick_marker(), pick_marker());
    set_bounds(0, 65);
    send_gap_pct <= 0;
    stall_pct <= 0;
    @(posedge clk);
    hold_go <= 1'b1;
    queue_frame(0, 1'b1);
    queue_frame(MAX_FRAME - 1, 1'b0);
    queue_frame(0, 1'b1);
    drain();

    $display("Sent %0d received words over reset, directed, four idling",
             words_taken);
    $display("and one back-pressure phase; got %0d frame words in %0d frames, %0d mismatched.",
             words_seen, frames_seen, mismatches);
    if (mismatches == 0 && due_words.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Watchdog for a block that hangs or loses frame words.
  initial begin
    #5_000_000;
    $display("Timed out with %0d frame words still owed.", due_words.size());
    $display("== FAIL ==");
    $finish;
  end

endmodule

`default_nettype wire
